[rtl/cpdp_pkg.sv]
// Shared types, constants and fixed-point helpers for the point projection datapath.
package cpdp_pkg;

  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 64;
  localparam int NormFrac  = 24;
  localparam int CoefFrac  = 28;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RADIAL_NUM = 3'd0,
    REG_RADIAL_MID = 3'd1,
    REG_RADIAL_DEN = 3'd2,
    REG_TANGENTIAL = 3'd3,
    REG_FOCAL      = 3'd4,
    REG_PRINCIPAL  = 3'd5,
    REG_SUBSAMPLE  = 3'd6
  } cfg_reg_e;

  typedef logic signed [65:0] prod_t;
  typedef logic signed [47:0] acc_t;

  localparam acc_t AccMax = 48'sh0000_7FFF_FFFF;
  localparam acc_t AccMin = -48'sh0000_8000_0000;
  localparam logic signed [31:0] S32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;
  localparam logic signed [31:0] OneQ28 = 32'sh1000_0000;

  typedef struct packed {
    logic              sat;
    logic signed [31:0] val;
  } sat_t;

  typedef struct packed {
    logic v;
    logic zpos;
    logic sat;
  } ctl_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] kab;
    logic signed [31:0] ta;
    logic signed [31:0] tb;
  } geo_t;

  typedef struct packed {
    geo_t               geo;
    logic               zpos;
    logic               sat;
    logic               denz;
    logic               negk;
    logic signed [31:0] kz;
  } krside_t;

  function automatic prod_t mul(input logic signed [32:0] x, input logic signed [32:0] y);
    return x * y;
  endfunction

  // round half away from zero, then arithmetic shift
  function automatic acc_t rnd(input prod_t p, input int unsigned sh);
    prod_t h;
    prod_t s;
    h = (prod_t'(1) <<< (sh - 1)) - $signed({65'd0, p[65]});
    s = (p + h) >>> sh;
    return acc_t'(s);
  endfunction

  function automatic sat_t sat32(input acc_t v);
    sat_t r;
    if (v > AccMax) begin
      r.sat = 1'b1;
      r.val = S32Max;
    end else if (v < AccMin) begin
      r.sat = 1'b1;
      r.val = S32Min;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  function automatic sat_t div_sat(input logic neg, input logic ovf, input logic [31:0] q);
    sat_t r;
    if (neg) begin
      if (ovf || (q > 32'h8000_0000)) begin
        r.sat = 1'b1;
        r.val = S32Min;
      end else begin
        r.sat = 1'b0;
        r.val = $signed(~q + 32'd1);
      end
    end else begin
      if (ovf || q[31]) begin
        r.sat = 1'b1;
        r.val = S32Max;
      end else begin
        r.sat = 1'b0;
        r.val = $signed(q);
      end
    end
    return r;
  endfunction

endpackage

[rtl/camera_point_distort_project.sv]
// Top level: projects a camera-frame point to a distorted, subsampled pixel position.
// Throughput: one item per cycle; busy_o stays low and start_i is taken every cycle.
// Three 17-stage pipelined dividers (depth normalization of x and y, rational radial factor) set the depth.
// Reset clears all configuration registers to zero and empties the pipeline.
// Results leave on done_o for one cycle; the receiver cannot stall them.
module camera_point_distort_project #(
  parameter int SUBSAMPLE_SHIFT = 1,
  parameter int FRAC_BITS       = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cfg_we_i,
  input  logic [cpdp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cpdp_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic signed [31:0]            cam_x_i,
  input  logic signed [31:0]            cam_y_i,
  input  logic signed [31:0]            cam_z_i,
  output logic                          done_o,
  output logic signed [31:0]            pixel_col_o,
  output logic signed [31:0]            pixel_row_o,
  output logic                          point_valid_o,
  output logic                          saturated_o
);

  import cpdp_pkg::*;

  localparam logic signed [31:0] MinusOne = -(32'sd1 <<< FRAC_BITS);
  localparam logic signed [32:0] SubHalf  = (33'sd1 <<< SUBSAMPLE_SHIFT) >>> 1;
  localparam logic               SubOn    = (SUBSAMPLE_SHIFT != 0);

  // configuration
  logic [63:0] k12_q, k34_q, k56_q, p12_q, foc_q, pp_q;
  logic        sub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k12_q <= '0;
      k34_q <= '0;
      k56_q <= '0;
      p12_q <= '0;
      foc_q <= '0;
      pp_q  <= '0;
      sub_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_RADIAL_NUM: k12_q <= cfg_wdata_i;
        REG_RADIAL_MID: k34_q <= cfg_wdata_i;
        REG_RADIAL_DEN: k56_q <= cfg_wdata_i;
        REG_TANGENTIAL: p12_q <= cfg_wdata_i;
        REG_FOCAL:      foc_q <= cfg_wdata_i;
        REG_PRINCIPAL:  pp_q  <= cfg_wdata_i;
        REG_SUBSAMPLE:  sub_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] k1, k2, k3, k4, k5, k6, p1, p2;
  logic        [31:0] fx, fy, cx, cy;
  assign k1 = $signed(k12_q[63:32]);
  assign k2 = $signed(k12_q[31:0]);
  assign k3 = $signed(k34_q[63:32]);
  assign k4 = $signed(k34_q[31:0]);
  assign k5 = $signed(k56_q[63:32]);
  assign k6 = $signed(k56_q[31:0]);
  assign p1 = $signed(p12_q[63:32]);
  assign p2 = $signed(p12_q[31:0]);
  assign fx = foc_q[63:32];
  assign fy = foc_q[31:0];
  assign cx = pp_q[63:32];
  assign cy = pp_q[31:0];

  assign busy_o = 1'b0;

  // stage 1: dividend preparation
  logic        zpos_in;
  logic [31:0] magx, magy, dz;
  assign zpos_in = (cam_z_i > 32'sd0);
  assign magx    = cam_x_i[31] ? 32'(-cam_x_i) : 32'(cam_x_i);
  assign magy    = cam_y_i[31] ? 32'(-cam_y_i) : 32'(cam_y_i);
  assign dz      = zpos_in ? 32'(cam_z_i) : 32'd1;

  logic        v1_q, zp1_q, nx1_q, ny1_q;
  logic [55:0] tx1_q, ty1_q;
  logic [31:0] dz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zp1_q <= zpos_in;
    nx1_q <= cam_x_i[31];
    ny1_q <= cam_y_i[31];
    tx1_q <= {magx, 24'd0} + 56'(dz[31:1]);
    ty1_q <= {magy, 24'd0} + 56'(dz[31:1]);
    dz1_q <= dz;
  end

  logic        va, vb, zpa, nxa, nyb, ovfa, ovfb;
  logic [31:0] qa, qb;

  cpdp_div #(.NW(56), .DW(32), .QW(32), .BPS(2), .SW(2)) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .num_i   (tx1_q),
    .den_i   (dz1_q),
    .side_i  ({zp1_q, nx1_q}),
    .valid_o (va),
    .quo_o   (qa),
    .ovf_o   (ovfa),
    .side_o  ({zpa, nxa})
  );

  cpdp_div #(.NW(56), .DW(32), .QW(32), .BPS(2), .SW(1)) u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .num_i   (ty1_q),
    .den_i   (dz1_q),
    .side_i  (ny1_q),
    .valid_o (vb),
    .quo_o   (qb),
    .ovf_o   (ovfb),
    .side_o  (nyb)
  );

  // stage 2: normalized coordinates
  sat_t sa, sb;
  assign sa = div_sat(nxa, ovfa, qa);
  assign sb = div_sat(nyb, ovfb, qb);

  ctl_t               ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q;
  logic signed [31:0] a2_q, b2_q, a3_q, b3_q, a4_q, b4_q, a5_q, b5_q;
  prod_t              paa3_q, pbb3_q, pab3_q;
  acc_t               raa4_q, rbb4_q, aa4_q, bb4_q, ab4_q;
  acc_t               aa5_q, bb5_q;
  logic signed [31:0] r2_5_q, kab5_q, r2_6_q;
  geo_t               geo6_q;
  sat_t               s_r2, s_kab, s_ta, s_tb;

  assign s_r2  = sat32(raa4_q + rbb4_q);
  assign s_kab = sat32(ab4_q);
  assign s_ta  = sat32(acc_t'(r2_5_q) + aa5_q);
  assign s_tb  = sat32(acc_t'(r2_5_q) + bb5_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
      ctl6_q <= '0;
    end else begin
      ctl2_q <= '{v: va & vb, zpos: zpa, sat: sa.sat | sb.sat};
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= '{v: ctl4_q.v, zpos: ctl4_q.zpos, sat: ctl4_q.sat | s_r2.sat | s_kab.sat};
      ctl6_q <= '{v: ctl5_q.v, zpos: ctl5_q.zpos, sat: ctl5_q.sat | s_ta.sat | s_tb.sat};
    end
  end

  always_ff @(posedge clk_i) begin
    a2_q   <= sa.val;
    b2_q   <= sb.val;
    paa3_q <= mul(33'(a2_q), 33'(a2_q));
    pbb3_q <= mul(33'(b2_q), 33'(b2_q));
    pab3_q <= mul(33'(a2_q), 33'(b2_q));
    a3_q   <= a2_q;
    b3_q   <= b2_q;
    raa4_q <= rnd(paa3_q, NormFrac);
    rbb4_q <= rnd(pbb3_q, NormFrac);
    aa4_q  <= rnd(paa3_q, NormFrac - 1);
    bb4_q  <= rnd(pbb3_q, NormFrac - 1);
    ab4_q  <= rnd(pab3_q, NormFrac - 1);
    a4_q   <= a3_q;
    b4_q   <= b3_q;
    r2_5_q <= s_r2.val;
    kab5_q <= s_kab.val;
    aa5_q  <= aa4_q;
    bb5_q  <= bb4_q;
    a5_q   <= a4_q;
    b5_q   <= b4_q;
    r2_6_q <= r2_5_q;
    geo6_q <= '{a: a5_q, b: b5_q, kab: kab5_q, ta: s_ta.val, tb: s_tb.val};
  end

  // numerator and denominator polynomials: three multiply, round, add steps
  logic signed [31:0] pin_r2 [3];
  logic signed [31:0] pin_n  [3];
  logic signed [31:0] pin_d  [3];
  geo_t               pin_geo[3];
  ctl_t               pin_ctl[3];
  logic signed [31:0] add_n  [3];
  logic signed [31:0] add_d  [3];

  prod_t              pa_n_q [3], pa_d_q [3];
  logic signed [31:0] pa_r2_q[3];
  geo_t               pa_geo_q[3];
  ctl_t               pa_ctl_q[3];
  acc_t               pb_n_q [3], pb_d_q [3];
  logic signed [31:0] pb_r2_q[3];
  geo_t               pb_geo_q[3];
  ctl_t               pb_ctl_q[3];
  logic signed [31:0] pc_n_q [3], pc_d_q [3];
  logic signed [31:0] pc_r2_q[3];
  geo_t               pc_geo_q[3];
  ctl_t               pc_ctl_q[3];

  assign add_n[0] = k2;
  assign add_n[1] = k1;
  assign add_n[2] = OneQ28;
  assign add_d[0] = k5;
  assign add_d[1] = k4;
  assign add_d[2] = OneQ28;

  for (genvar s = 0; s < 3; s++) begin : g_poly
    sat_t sn, sd;

    if (s == 0) begin : g_first
      assign pin_r2[s]  = r2_6_q;
      assign pin_n[s]   = k3;
      assign pin_d[s]   = k6;
      assign pin_geo[s] = geo6_q;
      assign pin_ctl[s] = ctl6_q;
    end else begin : g_next
      assign pin_r2[s]  = pc_r2_q[s-1];
      assign pin_n[s]   = pc_n_q[s-1];
      assign pin_d[s]   = pc_d_q[s-1];
      assign pin_geo[s] = pc_geo_q[s-1];
      assign pin_ctl[s] = pc_ctl_q[s-1];
    end

    assign sn = sat32(pb_n_q[s] + acc_t'(add_n[s]));
    assign sd = sat32(pb_d_q[s] + acc_t'(add_d[s]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pa_ctl_q[s] <= '0;
        pb_ctl_q[s] <= '0;
        pc_ctl_q[s] <= '0;
      end else begin
        pa_ctl_q[s] <= pin_ctl[s];
        pb_ctl_q[s] <= pa_ctl_q[s];
        pc_ctl_q[s] <= '{v: pb_ctl_q[s].v, zpos: pb_ctl_q[s].zpos,
                         sat: pb_ctl_q[s].sat | sn.sat | sd.sat};
      end
    end

    always_ff @(posedge clk_i) begin
      pa_n_q[s]   <= mul(33'(pin_r2[s]), 33'(pin_n[s]));
      pa_d_q[s]   <= mul(33'(pin_r2[s]), 33'(pin_d[s]));
      pa_r2_q[s]  <= pin_r2[s];
      pa_geo_q[s] <= pin_geo[s];
      pb_n_q[s]   <= rnd(pa_n_q[s], NormFrac);
      pb_d_q[s]   <= rnd(pa_d_q[s], NormFrac);
      pb_r2_q[s]  <= pa_r2_q[s];
      pb_geo_q[s] <= pa_geo_q[s];
      pc_n_q[s]   <= sn.val;
      pc_d_q[s]   <= sd.val;
      pc_r2_q[s]  <= pb_r2_q[s];
      pc_geo_q[s] <= pb_geo_q[s];
    end
  end

  // stage 7: radial factor dividend
  logic signed [31:0] num, den;
  logic        [31:0] magn, magd;
  assign num  = pc_n_q[2];
  assign den  = pc_d_q[2];
  assign magn = num[31] ? 32'(-num) : 32'(num);
  assign magd = den[31] ? 32'(-den) : 32'(den);

  logic        v7_q;
  logic [59:0] t7_q;
  logic [31:0] d7_q;
  krside_t     side7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= pc_ctl_q[2].v;
    end
  end

  always_ff @(posedge clk_i) begin
    t7_q            <= {magn, 28'd0} + 60'(magd[31:1]);
    d7_q            <= (den == 32'sd0) ? 32'd1 : magd;
    side7_q.geo     <= pc_geo_q[2];
    side7_q.zpos    <= pc_ctl_q[2].zpos;
    side7_q.sat     <= pc_ctl_q[2].sat;
    side7_q.denz    <= (den == 32'sd0);
    side7_q.negk    <= num[31] ^ den[31];
    side7_q.kz      <= (num > 32'sd0) ? S32Max : ((num < 32'sd0) ? S32Min : 32'sd0);
  end

  logic        vk, ovfk;
  logic [31:0] qk;
  krside_t     sidek;

  cpdp_div #(.NW(60), .DW(32), .QW(32), .BPS(2), .SW($bits(krside_t))) u_div_kr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .num_i   (t7_q),
    .den_i   (d7_q),
    .side_i  (side7_q),
    .valid_o (vk),
    .quo_o   (qk),
    .ovf_o   (ovfk),
    .side_o  (sidek)
  );

  // stage 8 onward: distortion and intrinsics
  sat_t skr;
  assign skr = sidek.denz ? sat_t'{sat: 1'b1, val: sidek.kz}
                          : div_sat(sidek.negk, ovfk, qk);

  ctl_t               ctl8_q, ctl9_q, ctl10_q, ctl11_q, ctl12_q, ctl13_q, ctl14_q;
  geo_t               geo8_q;
  logic signed [31:0] kr8_q;
  prod_t              pxa9_q, pxb9_q, pxc9_q, pya9_q, pyb9_q, pyc9_q;
  acc_t               rxa10_q, rxb10_q, rxc10_q, rya10_q, ryb10_q, ryc10_q;
  logic signed [31:0] xd11_q, yd11_q;
  prod_t              pc12_q, pr12_q;
  acc_t               rc13_q, rr13_q;
  logic signed [31:0] col14_q, row14_q;
  sat_t               s_xd, s_yd, s_col, s_row;

  assign s_xd  = sat32(rxa10_q + rxb10_q + rxc10_q);
  assign s_yd  = sat32(rya10_q + ryb10_q + ryc10_q);
  assign s_col = sat32(rc13_q + acc_t'($signed({1'b0, cx})));
  assign s_row = sat32(rr13_q + acc_t'($signed({1'b0, cy})));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl8_q  <= '0;
      ctl9_q  <= '0;
      ctl10_q <= '0;
      ctl11_q <= '0;
      ctl12_q <= '0;
      ctl13_q <= '0;
      ctl14_q <= '0;
    end else begin
      ctl8_q  <= '{v: vk, zpos: sidek.zpos, sat: sidek.sat | skr.sat};
      ctl9_q  <= ctl8_q;
      ctl10_q <= ctl9_q;
      ctl11_q <= '{v: ctl10_q.v, zpos: ctl10_q.zpos,
                   sat: ctl10_q.sat | s_xd.sat | s_yd.sat};
      ctl12_q <= ctl11_q;
      ctl13_q <= ctl12_q;
      ctl14_q <= '{v: ctl13_q.v, zpos: ctl13_q.zpos,
                   sat: ctl13_q.sat | s_col.sat | s_row.sat};
    end
  end

  always_ff @(posedge clk_i) begin
    geo8_q  <= sidek.geo;
    kr8_q   <= skr.val;
    pxa9_q  <= mul(33'(kr8_q), 33'(geo8_q.a));
    pxb9_q  <= mul(33'(geo8_q.kab), 33'(p1));
    pxc9_q  <= mul(33'(geo8_q.ta), 33'(p2));
    pya9_q  <= mul(33'(kr8_q), 33'(geo8_q.b));
    pyb9_q  <= mul(33'(geo8_q.kab), 33'(p2));
    pyc9_q  <= mul(33'(geo8_q.tb), 33'(p1));
    rxa10_q <= rnd(pxa9_q, CoefFrac);
    rxb10_q <= rnd(pxb9_q, CoefFrac);
    rxc10_q <= rnd(pxc9_q, CoefFrac);
    rya10_q <= rnd(pya9_q, CoefFrac);
    ryb10_q <= rnd(pyb9_q, CoefFrac);
    ryc10_q <= rnd(pyc9_q, CoefFrac);
    xd11_q  <= s_xd.val;
    yd11_q  <= s_yd.val;
    pc12_q  <= mul($signed({1'b0, fx}), 33'(xd11_q));
    pr12_q  <= mul($signed({1'b0, fy}), 33'(yd11_q));
    rc13_q  <= rnd(pc12_q, NormFrac);
    rr13_q  <= rnd(pr12_q, NormFrac);
    col14_q <= s_col.val;
    row14_q <= s_row.val;
  end

  // output stage: invalid-depth override and optional subsampling
  logic signed [31:0] sel_col, sel_row;
  logic signed [32:0] sub_col, sub_row;
  assign sel_col = ctl14_q.zpos ? col14_q : MinusOne;
  assign sel_row = ctl14_q.zpos ? row14_q : MinusOne;
  assign sub_col = (33'(sel_col) + SubHalf - $signed({32'd0, sel_col[31] & SubOn}))
                   >>> SUBSAMPLE_SHIFT;
  assign sub_row = (33'(sel_row) + SubHalf - $signed({32'd0, sel_row[31] & SubOn}))
                   >>> SUBSAMPLE_SHIFT;

  logic               done_q, pv_q, sat_q;
  logic signed [31:0] col_q, row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl14_q.v;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= sub_q ? sub_col[31:0] : sel_col;
    row_q <= sub_q ? sub_row[31:0] : sel_row;
    pv_q  <= ctl14_q.zpos;
    sat_q <= ctl14_q.zpos & ctl14_q.sat;
  end

  assign done_o        = done_q;
  assign pixel_col_o   = col_q;
  assign pixel_row_o   = row_q;
  assign point_valid_o = pv_q;
  assign saturated_o   = sat_q;

endmodule

[rtl/cpdp_div.sv]
// Pipelined restoring divider with quotient overflow flag and sideband.
module cpdp_div #(
  parameter int NW  = 56,
  parameter int DW  = 32,
  parameter int QW  = 32,
  parameter int BPS = 2,
  parameter int SW  = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o,
  output logic [SW-1:0] side_o
);

  localparam int NST = QW / BPS;

  logic          vld_q  [NST+1];
  logic [DW-1:0] rem_q  [NST+1];
  logic [QW-1:0] low_q  [NST+1];
  logic [QW-1:0] quo_q  [NST+1];
  logic          ovf_q  [NST+1];
  logic [DW-1:0] den_q  [NST+1];
  logic [SW-1:0] side_q [NST+1];

  logic [NW-1:0] hi;
  assign hi = num_i >> QW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q[0]  <= (hi >= NW'(den_i));
    rem_q[0]  <= hi[DW-1:0];
    low_q[0]  <= num_i[QW-1:0];
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    side_q[0] <= side_i;
  end

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [DW-1:0] rem_n;
    logic [QW-1:0] low_n;
    logic [QW-1:0] quo_n;

    always_comb begin
      logic [DW:0] cand;
      logic        qb;
      rem_n = rem_q[s];
      low_n = low_q[s];
      quo_n = quo_q[s];
      for (int i = 0; i < BPS; i++) begin
        cand  = {rem_n, low_n[QW-1]};
        qb    = (cand >= {1'b0, den_q[s]});
        if (qb) begin
          cand = cand - {1'b0, den_q[s]};
        end
        rem_n = cand[DW-1:0];
        low_n = {low_n[QW-2:0], 1'b0};
        quo_n = {quo_n[QW-2:0], qb};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= rem_n;
      low_q[s+1]  <= low_n;
      quo_q[s+1]  <= quo_n;
      ovf_q[s+1]  <= ovf_q[s];
      den_q[s+1]  <= den_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = vld_q[NST];
  assign quo_o   = quo_q[NST];
  assign ovf_o   = ovf_q[NST];
  assign side_o  = side_q[NST];

endmodule

[tb/camera_point_distort_project_tb.sv]
// Testbench for camera_point_distort_project: directed and random points checked against a predictor.
module camera_point_distort_project_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpdp_pkg::*;

  localparam int Shift = 1;
  localparam int Frac = 16;
  localparam int Latency = 58;
  localparam int WatchLimit = 4000;
  localparam longint I32Max = 64'sd2147483647;
  localparam longint I32Min = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] col;
    logic [31:0] row;
    logic        valid;
    logic        sat;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic signed [31:0] cam_x_i = '0, cam_y_i = '0, cam_z_i = '0;
  logic done_o;
  logic signed [31:0] pixel_col_o, pixel_row_o;
  logic point_valid_o, saturated_o;

  logic [63:0] lens_regs [7];
  pixel_t pending_pixels [$];
  int errors = 0;
  int idle_cycles = 0;
  int points_sent = 0;
  int pixels_checked = 0;
  int send_gap_pct = 0;
  bit clamped;

  camera_point_distort_project #(.SUBSAMPLE_SHIFT(Shift), .FRAC_BITS(Frac)) u_dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic longint sat_s32(longint v);
    if (v > I32Max) begin
      clamped = 1'b1;
      return I32Max;
    end
    if (v < I32Min) begin
      clamped = 1'b1;
      return I32Min;
    end
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint mul_round(longint x, longint y, int sh);
    bit neg;
    logic [63:0] m;
    neg = (x < 0) != (y < 0);
    m = abs64(x) * abs64(y);
    if (sh > 0) m = (m + (64'd1 << (sh - 1))) >> sh;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint div_round(longint n, longint d, int sh);
    bit neg;
    logic [63:0] un, ud, q;
    neg = (n < 0) != (d < 0);
    un = abs64(n) << sh;
    ud = abs64(d);
    q = (un + (ud >> 1)) / ud;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint rational_term(longint r2, longint c1, longint c2, longint c3);
    longint t;
    t = sat_s32(c2 + mul_round(r2, c3, NormFrac));
    t = sat_s32(c1 + mul_round(r2, t, NormFrac));
    return sat_s32((64'sd1 <<< CoefFrac) + mul_round(r2, t, NormFrac));
  endfunction

  function automatic longint hi_s(logic [63:0] r);
    return longint'($signed(r[63:32]));
  endfunction

  function automatic longint lo_s(logic [63:0] r);
    return longint'($signed(r[31:0]));
  endfunction

  function automatic longint shrink(longint v);
    return lens_regs[REG_SUBSAMPLE][0] ? mul_round(v, 1, Shift) : v;
  endfunction

  function automatic pixel_t project_point(longint x, longint y, longint z);
    pixel_t p;
    longint a, b, r2, num, den, kr, kab, ta, tb, xd, yd, col, row;
    clamped = 1'b0;
    if (z <= 0) begin
      col = shrink(-(64'sd1 <<< Frac));
      p.col = col[31:0];
      p.row = col[31:0];
      p.valid = 1'b0;
      p.sat = 1'b0;
      return p;
    end
    a = sat_s32(div_round(x, z, NormFrac));
    b = sat_s32(div_round(y, z, NormFrac));
    r2 = sat_s32(mul_round(a, a, NormFrac) + mul_round(b, b, NormFrac));
    num = rational_term(r2, hi_s(lens_regs[REG_RADIAL_NUM]), lo_s(lens_regs[REG_RADIAL_NUM]),
                        hi_s(lens_regs[REG_RADIAL_MID]));
    den = rational_term(r2, lo_s(lens_regs[REG_RADIAL_MID]), hi_s(lens_regs[REG_RADIAL_DEN]),
                        lo_s(lens_regs[REG_RADIAL_DEN]));
    if (den == 0) begin
      clamped = 1'b1;
      kr = num > 0 ? I32Max : (num < 0 ? I32Min : 0);
    end else begin
      kr = sat_s32(div_round(num, den, CoefFrac));
    end
    kab = sat_s32(mul_round(a, b, NormFrac - 1));
    ta = sat_s32(r2 + mul_round(a, a, NormFrac - 1));
    tb = sat_s32(r2 + mul_round(b, b, NormFrac - 1));
    xd = sat_s32(mul_round(kr, a, CoefFrac)
                 + mul_round(kab, hi_s(lens_regs[REG_TANGENTIAL]), CoefFrac)
                 + mul_round(ta, lo_s(lens_regs[REG_TANGENTIAL]), CoefFrac));
    yd = sat_s32(mul_round(kr, b, CoefFrac)
                 + mul_round(kab, lo_s(lens_regs[REG_TANGENTIAL]), CoefFrac)
                 + mul_round(tb, hi_s(lens_regs[REG_TANGENTIAL]), CoefFrac));
    col = shrink(sat_s32(mul_round(longint'(lens_regs[REG_FOCAL][63:32]), xd, NormFrac)
                         + longint'(lens_regs[REG_PRINCIPAL][63:32])));
    row = shrink(sat_s32(mul_round(longint'(lens_regs[REG_FOCAL][31:0]), yd, NormFrac)
                         + longint'(lens_regs[REG_PRINCIPAL][31:0])));
    p.col = col[31:0];
    p.row = row[31:0];
    p.valid = 1'b1;
    p.sat = clamped;
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h (pixel %0d)", what, got, want, pixels_checked);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", pixel_col_o, '0);
      end else begin
        pixel_t e;
        e = pending_pixels.pop_front();
        if (pixel_col_o !== e.col) report_mismatch("pixel_col", pixel_col_o, e.col);
        if (pixel_row_o !== e.row) report_mismatch("pixel_row", pixel_row_o, e.row);
        if (point_valid_o !== e.valid) report_mismatch("point_valid", point_valid_o, e.valid);
        if (saturated_o !== e.sat) report_mismatch("saturated", saturated_o, e.sat);
      end
      pixels_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog expired");
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    lens_regs[idx] = idx == REG_SUBSAMPLE ? {63'd0, val[0]} : val;
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < send_gap_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    cam_x_i <= x;
    cam_y_i <= y;
    cam_z_i <= z;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_pixels.push_back(project_point($signed(x), $signed(y), $signed(z)));
    points_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    start_i <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(3);
      default: return $urandom_range(32'h0100_0000, 32'h0000_4000);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    return $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0200_0000) - 32'h0100_0000;
  endfunction

  task automatic load_lens(bit wild);
    write_reg(REG_RADIAL_NUM, {rand_coef(), rand_coef()});
    write_reg(REG_RADIAL_MID, {rand_coef(), rand_coef()});
    write_reg(REG_RADIAL_DEN, {rand_coef(), rand_coef()});
    write_reg(REG_TANGENTIAL, {rand_coef(), rand_coef()});
    write_reg(REG_FOCAL, wild ? {$urandom(), $urandom()}
                              : {$urandom_range(32'h0400_0000), $urandom_range(32'h0400_0000)});
    write_reg(REG_PRINCIPAL, wild ? {$urandom(), $urandom()}
                                  : {$urandom_range(32'h0400_0000), $urandom_range(32'h0400_0000)});
    write_reg(REG_SUBSAMPLE, {63'd0, 1'($urandom())});
  endtask

  task automatic test_directed;
    write_reg(REG_FOCAL, {32'h0258_0000, 32'h0258_0000});
    write_reg(REG_PRINCIPAL, {32'h0140_0000, 32'h00F0_0000});
    send_point(32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
    send_point(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    drain();
    write_reg(REG_RADIAL_NUM, {32'h0100_0000, 32'hFF00_0000});
    write_reg(REG_RADIAL_MID, {32'h0080_0000, 32'hF000_0000});
    write_reg(REG_RADIAL_DEN, {32'h0000_0000, 32'h0000_0000});
    write_reg(REG_TANGENTIAL, {32'h0010_0000, 32'hFFF0_0000});
    write_reg(REG_SUBSAMPLE, 64'd1);
    send_point(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
    send_point(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
    send_point(32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000);
    drain();
    write_reg(REG_RADIAL_NUM, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(REG_RADIAL_MID, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(REG_RADIAL_DEN, {32'h7FFF_FFFF, 32'h8000_0000});
    write_reg(REG_TANGENTIAL, {32'h8000_0000, 32'h7FFF_FFFF});
    write_reg(REG_FOCAL, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
    write_reg(REG_PRINCIPAL, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
    write_reg(REG_SUBSAMPLE, 64'd0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000);
    send_point(32'h0000_0100, 32'hFFFF_FF00, 32'h0001_0000);
    drain();
  endtask

  task automatic test_random(int gap_pct, int n);
    send_gap_pct = gap_pct;
    for (int blk = 0; blk < 6; blk++) begin
      load_lens(blk == 5);
      for (int i = 0; i < n / 6; i++) send_point(rand_coord(), rand_coord(), rand_depth());
      drain();
    end
  endtask

  initial begin
    foreach (lens_regs[i]) lens_regs[i] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(13, 630);
    test_random(58, 630);
    test_random(0, 630);
    $display("%0d points sent, %0d pixels checked over directed and random lens settings",
             points_sent, pixels_checked);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
rtl/cpdp_pkg.sv
rtl/cpdp_div.sv
rtl/camera_point_distort_project.sv
tb/camera_point_distort_project_tb.sv
